### hdl/svr_pkg.sv
// shared types, constants and the crc-32 byte update for the sector record validator
// no dependencies; imported by every module of the block
package svr_pkg;

  // sector framing
  localparam logic [31:0] MAGIC_WORD   = 32'h344D_4354;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MASK   = 16'hFFFF;
  localparam int          ENTRY_LIMIT  = 512;
  localparam int          SECTOR_BYTES = 4096;

  // byte position and header landmarks
  localparam int          POS_W        = 13;
  localparam int          END_W        = 19;
  localparam logic [POS_W-1:0] POS_MAX   = 13'd8191;
  localparam logic [POS_W-1:0] POS_MAGIC = 13'd3;
  localparam logic [POS_W-1:0] POS_NONCE = 13'd7;
  localparam logic [POS_W-1:0] POS_X     = 13'd11;
  localparam logic [POS_W-1:0] POS_Z     = 13'd15;
  localparam logic [POS_W-1:0] POS_COUNT = 13'd19;
  localparam logic [POS_W-1:0] HDR_BYTES = 13'd20;

  // configuration port
  localparam int   CFG_ADDR_W     = 3;
  localparam logic REG_NONCE_SLOT = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_NONCE     = 3'd2,
    ST_COUNT     = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_CRC       = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         status;
    logic signed [31:0] chunk_x;
    logic signed [31:0] chunk_z;
    logic [9:0]         entry_count;
  } out_item_t;

  // reflected crc-32, one byte, eight bit steps
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### hdl/sector_record_validator.sv
// top level: byte input register, check core, verdict register and the register port
// depends on svr_pkg and svr_check_core
//
// Takes one sector byte per clock cycle, back to back, and returns one verdict per
// sector from the verdict register. Each byte passes through an input register, a
// combinational check stage (an eight-step crc-32 byte update and the header
// compares) and, for the last byte, a verdict register. The input stalls only
// while a last byte waits behind a verdict that is itself stalled. The expected nonce
// lives at byte address 0 of the register port and should be written between sectors.
module sector_record_validator #(
  parameter int MAX_COUNT   = svr_pkg::ENTRY_LIMIT,
  parameter int SECTOR_SIZE = svr_pkg::SECTOR_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  svr_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output svr_pkg::out_item_t               out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [svr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import svr_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  verdict;
  logic [31:0] nonce_r;
  logic       advance;
  logic       in_take;
  logic       cfg_write;

  // pipeline control
  always_comb begin
    advance       = s1_valid_r && !(s1_data_r.last_byte && out_valid_r && out_stall);
    in_stall      = s1_valid_r && !advance;
    in_take       = in_valid && !in_stall;
    s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = (advance && s1_data_r.last_byte) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  svr_check_core #(
    .MAX_COUNT   (MAX_COUNT),
    .SECTOR_SIZE (SECTOR_SIZE)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (s1_data_r),
    .expected_nonce (nonce_r),
    .verdict        (verdict)
  );

  // verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance && s1_data_r.last_byte) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register port, written in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NONCE_SLOT);
  assign prdata    = (paddr[2] == REG_NONCE_SLOT) ? nonce_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_r <= '0;
    end else if (cfg_write) begin
      nonce_r <= pwdata;
    end
  end

endmodule

### hdl/svr_check_core.sv
// per-sector state and the header, length and checksum checks for one byte
// depends on svr_pkg (types, landmarks, crc32_byte)
module svr_check_core #(
  parameter int MAX_COUNT   = svr_pkg::ENTRY_LIMIT,
  parameter int SECTOR_SIZE = svr_pkg::SECTOR_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  svr_pkg::in_item_t  item,
  input  logic [31:0]        expected_nonce,
  output svr_pkg::out_item_t verdict
);
  import svr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [31:0]      cx_r, cx_nxt;
  logic [31:0]      cz_r, cz_nxt;
  logic [15:0]      count_r, count_nxt;
  logic [31:0]      snap_r, snap_nxt;
  status_t          fault_r, fault_nxt;

  logic [END_W-1:0] idx;
  logic [END_W-1:0] body_end;
  logic [END_W-1:0] body_end_new;
  logic [END_W-1:0] fit_end;
  logic             in_body;
  logic [31:0]      crc_upd;
  status_t          final_status;

  // running checksum and the word window
  always_comb begin
    idx      = {{(END_W-POS_W){1'b0}}, pos_r};
    body_end = {{(END_W-POS_W){1'b0}}, HDR_BYTES} + {1'b0, count_r, 2'b00};
    word_nxt = {item.sector_byte, word_r[31:8]};
    in_body  = idx < body_end;
    crc_upd  = crc32_byte(crc_r, item.sector_byte);
    crc_nxt  = in_body ? crc_upd : crc_r;
    snap_nxt = (in_body && (idx + 19'd1 == body_end)) ? ~crc_upd : snap_r;
    pos_nxt  = (pos_r < POS_MAX) ? pos_r + 13'd1 : pos_r;
  end

  // header fields and the first failing check
  always_comb begin
    fault_nxt = fault_r;
    cx_nxt    = cx_r;
    cz_nxt    = cz_r;
    count_nxt = count_r;
    fit_end   = 19'd24 + {1'b0, word_nxt[15:0] & COUNT_MASK, 2'b00};
    if (fault_r == ST_OK) begin
      if (pos_r == POS_MAGIC && word_nxt != MAGIC_WORD) begin
        fault_nxt = ST_BAD_MAGIC;
      end else if (pos_r == POS_NONCE && word_nxt != expected_nonce) begin
        fault_nxt = ST_NONCE;
      end else if (pos_r == POS_X) begin
        cx_nxt = word_nxt;
      end else if (pos_r == POS_Z) begin
        cz_nxt = word_nxt;
      end else if (pos_r == POS_COUNT) begin
        count_nxt = word_nxt[15:0] & COUNT_MASK;
        if ({3'd0, count_nxt} > END_W'(MAX_COUNT)) begin
          fault_nxt = ST_COUNT;
        end else if (fit_end > END_W'(SECTOR_SIZE)) begin
          fault_nxt = ST_OVERRUN;
        end
      end else if (pos_r >= HDR_BYTES && idx == body_end + 19'd3 && word_nxt != snap_r) begin
        fault_nxt = ST_CRC;
      end
    end else if (pos_r == POS_X) begin
      cx_nxt = word_nxt;
    end else if (pos_r == POS_Z) begin
      cz_nxt = word_nxt;
    end
  end

  // verdict for a last byte; a short sector counts as a checksum mismatch
  always_comb begin
    body_end_new = {{(END_W-POS_W){1'b0}}, HDR_BYTES} + {1'b0, count_nxt, 2'b00};
    final_status = fault_nxt;
    if (fault_nxt == ST_OK && (pos_r < POS_COUNT || idx < body_end_new + 19'd3)) begin
      final_status = ST_CRC;
    end
    verdict.accepted    = (final_status == ST_OK);
    verdict.status      = final_status;
    verdict.chunk_x     = cx_nxt;
    verdict.chunk_z     = cz_nxt;
    verdict.entry_count = (final_status == ST_OK) ? count_nxt[9:0] : 10'd0;
  end

  // state update; a last byte returns the sector state to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      word_r  <= '0;
      cx_r    <= '0;
      cz_r    <= '0;
      count_r <= '0;
      snap_r  <= '0;
      fault_r <= ST_OK;
    end else if (step) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      word_r  <= word_nxt;
      cx_r    <= cx_nxt;
      cz_r    <= cz_nxt;
      count_r <= count_nxt;
      snap_r  <= snap_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

### hdl/svr_checker.sv
// port-level checks on the sector record validator and the bind that attaches them
// depends on svr_pkg and the top level sector_record_validator
module svr_checker #(
  parameter int MAX_COUNT = svr_pkg::ENTRY_LIMIT
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input svr_pkg::out_item_t out_data
);
  import svr_pkg::*;

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("verdict changed while stalled");

  // accepted flag agrees with the status code
  a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.status == ST_OK)))
    else $error("accepted flag disagrees with status");

  // a rejected sector reports no entries, an accepted one stays within the limit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted ? ({1'b0, out_data.entry_count} <= 11'(MAX_COUNT))
                                     : (out_data.entry_count == 10'd0)))
    else $error("entry count inconsistent with verdict");

  // status code is one of the defined verdicts
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_CRC))
    else $error("undefined status code");

  // no verdict straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict presented after reset");

endmodule

bind sector_record_validator svr_checker #(.MAX_COUNT(MAX_COUNT)) u_svr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
